[rtl/fcs_pkg.sv]
// Shared types, constants and helper functions for the flight control command shaper.
// Used by fcs_cfg, fcs_mul and the top level flight_control_command_shaper.
// Depends on nothing else.
`default_nettype none

package fcs_pkg;

    // Q1.14 unity and fixed thresholds
    localparam logic signed [15:0] Q_ONE            = 16'sd16384;
    localparam logic [14:0]        BRAKE_THRESH     = 15'd819;
    localparam logic signed [15:0] TRIM_DEADBAND    = 16'sd327;
    localparam logic [14:0]        SLAT_FLAP_THRESH = 15'd163;

    // Configuration register indexes
    localparam logic [7:0] REG_MAX_ELEVATOR = 8'd0;
    localparam logic [7:0] REG_MAX_AILERON  = 8'd1;
    localparam logic [7:0] REG_MAX_RUDDER   = 8'd2;
    localparam logic [7:0] REG_SURFACE_RATE = 8'd3;
    localparam logic [7:0] REG_TRIM_RATE    = 8'd4;
    localparam logic [7:0] REG_SLAT_RATE    = 8'd5;
    localparam logic [7:0] REG_FLAP_STEP    = 8'd6;
    localparam logic [7:0] REG_TRIM_LIMIT   = 8'd7;

    // Channel widths
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 152;
    localparam int MUL_A_W    = 16;
    localparam int MUL_B_W    = 32;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic [14:0] max_elevator;
        logic [14:0] max_aileron;
        logic [14:0] max_rudder;
        logic [15:0] surface_rate;
        logic [15:0] trim_rate;
        logic [15:0] slat_rate;
        logic [14:0] flap_step;
        logic [14:0] trim_limit;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIM,
        ST_PT,
        ST_PS,
        ST_ELEV,
        ST_AIL,
        ST_RUD,
        ST_TRIM,
        ST_SLAT,
        ST_FIN,
        ST_OUT
    } state_t;

    // Clamp a Q1.14 value to the range -1 .. +1.
    function automatic logic signed [15:0] clamp_unit(input logic signed [15:0] v);
        logic signed [15:0] r;
        if (v > Q_ONE)
            r = Q_ONE;
        else if (v < -Q_ONE)
            r = -Q_ONE;
        else
            r = v;
        return r;
    endfunction

    // Magnitude of a signed 16-bit value; the most negative code gives 0x8000.
    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        logic signed [16:0] w;
        w = 17'(v);
        if (v < 0)
            w = -w;
        return w[15:0];
    endfunction

endpackage

`default_nettype wire

[rtl/fcs_cfg.sv]
// Configuration register bank for the flight control command shaper.
// Depends on fcs_pkg for the register indexes and the cfg_t record.
`default_nettype none

module fcs_cfg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_en,
    input  wire logic [7:0]   wr_index,
    input  wire logic [15:0]  wr_data,
    output fcs_pkg::cfg_t     cfg
);

    fcs_pkg::cfg_t cfg_reg;
    fcs_pkg::cfg_t cfg_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_elevator <= 15'd8192;
            cfg_reg.max_aileron  <= 15'd8192;
            cfg_reg.max_rudder   <= 15'd8192;
            cfg_reg.surface_rate <= 16'd12288;
            cfg_reg.trim_rate    <= 16'd4096;
            cfg_reg.slat_rate    <= 16'd8192;
            cfg_reg.flap_step    <= 15'd4096;
            cfg_reg.trim_limit   <= 15'd15360;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Writes are masked to the width of the addressed register; unknown indexes are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                fcs_pkg::REG_MAX_ELEVATOR: cfg_next.max_elevator = wr_data[14:0];
                fcs_pkg::REG_MAX_AILERON:  cfg_next.max_aileron  = wr_data[14:0];
                fcs_pkg::REG_MAX_RUDDER:   cfg_next.max_rudder   = wr_data[14:0];
                fcs_pkg::REG_SURFACE_RATE: cfg_next.surface_rate = wr_data;
                fcs_pkg::REG_TRIM_RATE:    cfg_next.trim_rate    = wr_data;
                fcs_pkg::REG_SLAT_RATE:    cfg_next.slat_rate    = wr_data;
                fcs_pkg::REG_FLAP_STEP:    cfg_next.flap_step    = wr_data[14:0];
                fcs_pkg::REG_TRIM_LIMIT:   cfg_next.trim_limit   = wr_data[14:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/fcs_mul.sv]
// Shared sign-magnitude multiplier with a registered product.
// Depends on fcs_pkg for the operand and product widths.
`default_nettype none

module fcs_mul (
    input  wire logic                          clk,
    input  wire logic [fcs_pkg::MUL_A_W-1:0]   a_mag,
    input  wire logic                          a_neg,
    input  wire logic [fcs_pkg::MUL_B_W-1:0]   b,
    output logic      [fcs_pkg::MUL_P_W-1:0]   prod,
    output logic                               prod_neg
);

    logic [fcs_pkg::MUL_P_W-1:0] prod_reg;
    logic                        neg_reg;

    // The magnitude is kept apart from the sign so that truncation is toward zero.
    always_ff @(posedge clk)
    begin
        prod_reg <= fcs_pkg::MUL_P_W'(a_mag) * fcs_pkg::MUL_P_W'(b);
        neg_reg  <= a_neg;
    end

    assign prod     = prod_reg;
    assign prod_neg = neg_reg;

endmodule

`default_nettype wire

[rtl/flight_control_command_shaper.sv]
// Top level of the flight control command shaper: sequencer, state and result register.
// Depends on fcs_pkg, fcs_cfg (register bank) and fcs_mul (shared multiplier).
//
// Usage. One pilot-input snapshot per simulation tick arrives as a transfer on the
// s_axis channel; one shaped command set leaves as a transfer on the m_axis channel.
// Configuration registers are written through the cfg channel, which is always ready;
// writes should only be made while no snapshot is being processed.
//
// Sequencing. A snapshot is taken when s_axis_tready is high, which is the
// case only while the sequencer is idle. Eight products (the step limit, two rate-times-
// time-step products, three surface targets, the trim and the slat change) pass one
// after another through the single 16 x 32 multiplier before the result is written into
// the output register, and no new snapshot is accepted until the sequencer has written
// the result of the last one. The multiplier is the unit that sets the pace.
//
// Stalling. The result waits in the output register until m_axis_tready is high. The
// next snapshot is still taken and worked on meanwhile; only its final step waits for
// the output register to be free.
//
// Reset. rst_n clears the surfaces, trim, flaps, slats and latched switches to zero,
// loads the register defaults and leaves the output channel empty.
`default_nettype none

module flight_control_command_shaper (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // s_axis_tdata, from bit 0 up: pitch_stick[16], roll_stick[16], pedal[16],
    // throttle_in[16], tiller_in[16], brake_pedal[16], trim_command[16],
    // time_step[16], toggle_flags[8]
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [fcs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // m_axis_tdata, from bit 0 up: elevator_out[16], aileron_out[16], rudder_out[16],
    // throttle_out[15], brake_out[15], brake_on[1], steer_out[16], trim_out[16],
    // flap_out[15], slat_out[15], switch_states[6], zero padding[5]
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [fcs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [7:0]                        cfg_index,
    input  wire logic [15:0]                       cfg_data
);

    fcs_pkg::cfg_t   cfg;
    fcs_pkg::state_t state_reg;
    fcs_pkg::state_t state_next;

    // Snapshot register
    logic [fcs_pkg::IN_DATA_W-1:0]  in_reg;
    logic [fcs_pkg::IN_DATA_W-1:0]  in_next;

    // Persistent state
    logic signed [15:0] elev_reg, elev_next;
    logic signed [15:0] ail_reg,  ail_next;
    logic signed [15:0] rud_reg,  rud_next;
    logic signed [15:0] trim_reg, trim_next;
    logic [14:0]        flap_reg, flap_next;
    logic [14:0]        slat_reg, slat_next;
    logic [5:0]         latch_reg, latch_next;

    // Intermediate products kept between steps
    logic [17:0]        lim_reg, lim_next;
    logic [31:0]        pt_reg,  pt_next;
    logic [31:0]        ps_reg,  ps_next;

    // Result register
    logic [fcs_pkg::OUT_DATA_W-1:0] out_reg, out_next;
    logic                           out_valid_reg, out_valid_next;

    // Multiplier connections
    logic [fcs_pkg::MUL_A_W-1:0]    mul_a;
    logic                           mul_neg;
    logic [fcs_pkg::MUL_B_W-1:0]    mul_b;
    logic [fcs_pkg::MUL_P_W-1:0]    prod;
    logic                           prod_neg;

    // Snapshot fields
    logic signed [15:0] pitch_s, roll_s, pedal_s, throttle_s, tiller_s, brake_s, tc_s;
    logic [15:0]        dt;
    logic [7:0]         flags;

    // Working signals
    logic signed [15:0] tgt;
    logic signed [17:0] flap_a, flap_b;
    logic signed [17:0] trim_delta, trim_sum, trim_lm;
    logic signed [19:0] slat_sum;
    logic signed [15:0] slat_diff;
    logic               trim_active;
    logic               out_free;
    logic signed [15:0] thr_c, brk_c, steer_c;

    assign pitch_s    = $signed(in_reg[15:0]);
    assign roll_s     = $signed(in_reg[31:16]);
    assign pedal_s    = $signed(in_reg[47:32]);
    assign throttle_s = $signed(in_reg[63:48]);
    assign tiller_s   = $signed(in_reg[79:64]);
    assign brake_s    = $signed(in_reg[95:80]);
    assign tc_s       = $signed(in_reg[111:96]);
    assign dt         = in_reg[127:112];
    assign flags      = in_reg[135:128];

    // Moves a surface toward its target by no more than the step limit.
    function automatic logic signed [15:0] surf_step(
        input logic signed [15:0] pos,
        input logic signed [15:0] target,
        input logic [17:0]        lim
    );
        logic signed [18:0] diff;
        logic signed [18:0] lims;
        logic signed [18:0] res;
        diff = 19'(target) - 19'(pos);
        lims = $signed({1'b0, lim});
        if (diff > lims)
            res = 19'(pos) + lims;
        else if (diff < -lims)
            res = 19'(pos) - lims;
        else
            res = 19'(target);
        return res[15:0];
    endfunction

    fcs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    fcs_mul u_mul (
        .clk      (clk),
        .a_mag    (mul_a),
        .a_neg    (mul_neg),
        .b        (mul_b),
        .prod     (prod),
        .prod_neg (prod_neg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fcs_pkg::ST_IDLE;
            elev_reg      <= '0;
            ail_reg       <= '0;
            rud_reg       <= '0;
            trim_reg      <= '0;
            flap_reg      <= '0;
            slat_reg      <= '0;
            latch_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            elev_reg      <= elev_next;
            ail_reg       <= ail_next;
            rud_reg       <= rud_next;
            trim_reg      <= trim_next;
            flap_reg      <= flap_next;
            slat_reg      <= slat_next;
            latch_reg     <= latch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        in_reg  <= in_next;
        lim_reg <= lim_next;
        pt_reg  <= pt_next;
        ps_reg  <= ps_next;
        out_reg <= out_next;
    end

    // The surface target is the registered product scaled back from Q1.14 and signed.
    always_comb
    begin
        if (prod_neg)
            tgt = -$signed({1'b0, prod[28:14]});
        else
            tgt = $signed({1'b0, prod[28:14]});
    end

    always_comb
    begin
        state_next     = state_reg;
        in_next        = in_reg;
        elev_next      = elev_reg;
        ail_next       = ail_reg;
        rud_next       = rud_reg;
        trim_next      = trim_reg;
        flap_next      = flap_reg;
        slat_next      = slat_reg;
        latch_next     = latch_reg;
        lim_next       = lim_reg;
        pt_next        = pt_reg;
        ps_next        = ps_reg;
        out_next       = out_reg;
        mul_a          = '0;
        mul_neg        = 1'b0;
        mul_b          = '0;
        flap_a         = '0;
        flap_b         = '0;
        trim_delta     = '0;
        trim_sum       = '0;
        trim_lm        = $signed({3'b000, cfg.trim_limit});
        slat_sum       = '0;
        slat_diff      = '0;
        thr_c          = '0;
        brk_c          = '0;
        steer_c        = '0;
        trim_active    = (tc_s > fcs_pkg::TRIM_DEADBAND) || (tc_s < -fcs_pkg::TRIM_DEADBAND);
        out_free       = !out_valid_reg || m_axis_tready;
        s_axis_tready  = (state_reg == fcs_pkg::ST_IDLE);

        // The output register empties on a transfer and refills in the last step.
        out_valid_next = out_valid_reg && !m_axis_tready;

        unique case (state_reg)
            fcs_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    in_next    = s_axis_tdata;
                    state_next = fcs_pkg::ST_LIM;
                end
            end

            fcs_pkg::ST_LIM:
            begin
                mul_a = cfg.surface_rate;
                mul_b = 32'(dt);
                // Flap detents: down step first, then up, each clamped to 0 .. 1.
                flap_a = $signed({3'b000, flap_reg});
                if (flags[1])
                begin
                    flap_a = flap_a + $signed({3'b000, cfg.flap_step});
                    if (flap_a > 18'sd16384)
                        flap_a = 18'sd16384;
                end
                flap_b = flap_a;
                if (flags[2])
                begin
                    flap_b = flap_a - $signed({3'b000, cfg.flap_step});
                    if (flap_b < 18'sd0)
                        flap_b = 18'sd0;
                end
                flap_next = flap_b[14:0];
                // Parking brake only latches on; the other switches toggle.
                latch_next = {latch_reg[5:1] ^ flags[7:3], latch_reg[0] | flags[0]};
                state_next = fcs_pkg::ST_PT;
            end

            fcs_pkg::ST_PT:
            begin
                lim_next   = prod[31:14];
                mul_a      = cfg.trim_rate;
                mul_b      = 32'(dt);
                state_next = fcs_pkg::ST_PS;
            end

            fcs_pkg::ST_PS:
            begin
                pt_next    = prod[31:0];
                mul_a      = cfg.slat_rate;
                mul_b      = 32'(dt);
                state_next = fcs_pkg::ST_ELEV;
            end

            fcs_pkg::ST_ELEV:
            begin
                ps_next    = prod[31:0];
                mul_a      = fcs_pkg::mag16(fcs_pkg::clamp_unit(pitch_s));
                mul_neg    = pitch_s[15];
                mul_b      = 32'(cfg.max_elevator);
                state_next = fcs_pkg::ST_AIL;
            end

            fcs_pkg::ST_AIL:
            begin
                elev_next  = surf_step(elev_reg, tgt, lim_reg);
                mul_a      = fcs_pkg::mag16(fcs_pkg::clamp_unit(roll_s));
                mul_neg    = roll_s[15];
                mul_b      = 32'(cfg.max_aileron);
                state_next = fcs_pkg::ST_RUD;
            end

            fcs_pkg::ST_RUD:
            begin
                ail_next   = surf_step(ail_reg, tgt, lim_reg);
                mul_a      = fcs_pkg::mag16(fcs_pkg::clamp_unit(pedal_s));
                mul_neg    = pedal_s[15];
                mul_b      = 32'(cfg.max_rudder);
                state_next = fcs_pkg::ST_TRIM;
            end

            fcs_pkg::ST_TRIM:
            begin
                rud_next   = surf_step(rud_reg, tgt, lim_reg);
                mul_a      = fcs_pkg::mag16(tc_s);
                mul_neg    = tc_s[15];
                mul_b      = pt_reg;
                state_next = fcs_pkg::ST_SLAT;
            end

            fcs_pkg::ST_SLAT:
            begin
                // Trim integrates only outside the deadband, then saturates.
                if (prod_neg)
                    trim_delta = -$signed({3'b000, prod[46:32]});
                else
                    trim_delta = $signed({3'b000, prod[46:32]});
                trim_sum = 18'(trim_reg) + trim_delta;
                if (trim_sum > trim_lm)
                    trim_sum = trim_lm;
                if (trim_sum < -trim_lm)
                    trim_sum = -trim_lm;
                if (trim_active)
                    trim_next = trim_sum[15:0];
                // Slats ramp fully out once the flap setting exceeds SLAT_FLAP_THRESH, fully in otherwise.
                if (flap_reg > fcs_pkg::SLAT_FLAP_THRESH)
                    slat_diff = fcs_pkg::Q_ONE - $signed({1'b0, slat_reg});
                else
                    slat_diff = -$signed({1'b0, slat_reg});
                mul_a      = fcs_pkg::mag16(slat_diff);
                mul_neg    = slat_diff[15];
                mul_b      = ps_reg;
                state_next = fcs_pkg::ST_FIN;
            end

            fcs_pkg::ST_FIN:
            begin
                if (prod_neg)
                    slat_sum = 20'(slat_reg) - 20'(prod[45:28]);
                else
                    slat_sum = 20'(slat_reg) + 20'(prod[45:28]);
                if (slat_sum < 20'sd0)
                    slat_sum = 20'sd0;
                if (slat_sum > 20'sd16384)
                    slat_sum = 20'sd16384;
                slat_next  = slat_sum[14:0];
                state_next = fcs_pkg::ST_OUT;
            end

            fcs_pkg::ST_OUT:
            begin
                if (throttle_s < 16'sd0)
                    thr_c = 16'sd0;
                else if (throttle_s > fcs_pkg::Q_ONE)
                    thr_c = fcs_pkg::Q_ONE;
                else
                    thr_c = throttle_s;
                // A latched parking brake holds the brake at full unless the pedal asks more.
                if (latch_reg[0] && (brake_s < fcs_pkg::Q_ONE))
                    brk_c = fcs_pkg::Q_ONE;
                else if (brake_s < 16'sd0)
                    brk_c = 16'sd0;
                else if (brake_s > fcs_pkg::Q_ONE)
                    brk_c = fcs_pkg::Q_ONE;
                else
                    brk_c = brake_s;
                steer_c = fcs_pkg::clamp_unit(tiller_s);
                if (out_free)
                begin
                    out_next = {5'b00000, latch_reg, slat_reg, flap_reg, trim_reg, steer_c,
                                (brk_c[14:0] > fcs_pkg::BRAKE_THRESH), brk_c[14:0],
                                thr_c[14:0], rud_reg, ail_reg, elev_reg};
                    out_valid_next = 1'b1;
                    state_next     = fcs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = fcs_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;
    assign cfg_ready     = 1'b1;

endmodule

`default_nettype wire
